FILE: rtl/core/bfd_pkg.sv
// Shared types, register indexes, status codes and the CRC-16/MODBUS byte update.
package bfd_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int StW   = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [ByteW-1:0] HeadReset    = 8'hAA;
  localparam logic [ByteW-1:0] TailReset    = 8'h55;
  localparam logic [ByteW-1:0] FirstVerReset  = 8'h01;
  localparam logic [ByteW-1:0] SecondVerReset = 8'h02;
  localparam logic [LenW-1:0]  MaxPayReset  = 16'd255;
  localparam logic [15:0]      CrcInit      = 16'hFFFF;
  localparam logic [15:0]      CrcPoly      = 16'hA001;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD    = 3'd0,
    REG_TAIL    = 3'd1,
    REG_VER1    = 3'd2,
    REG_VER2    = 3'd3,
    REG_MAXPAY  = 3'd4
  } reg_idx_t;

  typedef enum logic [StW-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_TAIL = 3'd1,
    ST_BAD_VER  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_BAD_CRC  = 3'd4
  } frame_status_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [8:0] {
    S_HUNT   = 9'b000000001,
    S_VER    = 9'b000000010,
    S_TYPE   = 9'b000000100,
    S_LEN_LO = 9'b000001000,
    S_LEN_HI = 9'b000010000,
    S_PAY    = 9'b000100000,
    S_CRC_LO = 9'b001000000,
    S_CRC_HI = 9'b010000000,
    S_TAIL   = 9'b100000000
  } fsm_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [StW-1:0]   status;
    logic [ByteW-1:0] frame_version;
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  frame_length;
  } result_t;

  // one byte through the reflected polynomial, bit by bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [ByteW-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ble_frame_deframer_crc16_top.sv
// Length-prefixed frame deframer with running CRC-16/MODBUS and a two-word output queue.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | byte_value
//  output   | out_valid / out_ready  | kind, data_byte, status, frame_version,
//           |                        | frame_type, frame_length
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle while in_ready is high: the frame state, counter compare and byte-wide CRC update
// sit between the input handshake and the output register.
// Results go to an output register backed by one skid entry; in_ready drops only
// while the skid entry is full.
// Synchronous active-high reset returns to hunting and restores register defaults.
// cfg_ready is always high; writes take effect on the next word.
module ble_frame_deframer_crc16_top
  import bfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ByteW-1:0]    byte_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [ByteW-1:0]    data_byte,
  output logic [StW-1:0]      status,
  output logic [ByteW-1:0]    frame_version,
  output logic [ByteW-1:0]    frame_type,
  output logic [LenW-1:0]     frame_length,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [ByteW-1:0] head_byte, tail_byte, first_version, second_version;
  logic [LenW-1:0]  max_payload;

  fsm_t             state, state_next;
  logic [LenW-1:0]  payload_len, payload_len_next;
  logic [LenW-1:0]  remain, remain_next;
  logic [ByteW-1:0] version_seen, version_seen_next;
  logic [ByteW-1:0] type_seen, type_seen_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [ByteW-1:0] crc_low_byte, crc_low_byte_next;

  result_t          res, out_reg, skid_reg;
  logic             has_res;
  logic             skid_valid;
  logic             in_fire, push, pop;
  logic [15:0]      crc_upd;
  logic [LenW-1:0]  len_full;
  logic             ver_in_ok, ver_seen_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign push      = in_fire && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte      <= HeadReset;
      tail_byte      <= TailReset;
      first_version  <= FirstVerReset;
      second_version <= SecondVerReset;
      max_payload    <= MaxPayReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEAD:   head_byte      <= cfg_data[ByteW-1:0];
        REG_TAIL:   tail_byte      <= cfg_data[ByteW-1:0];
        REG_VER1:   first_version  <= cfg_data[ByteW-1:0];
        REG_VER2:   second_version <= cfg_data[ByteW-1:0];
        REG_MAXPAY: max_payload    <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign crc_upd     = crc16_byte((state == S_VER) ? CrcInit : running_crc, byte_value);
  assign len_full    = {byte_value, payload_len[ByteW-1:0]};
  assign ver_in_ok   = (byte_value == first_version) || (byte_value == second_version);
  assign ver_seen_ok = (version_seen == first_version) || (version_seen == second_version);

  always_comb begin
    state_next        = state;
    payload_len_next  = payload_len;
    remain_next       = remain;
    version_seen_next = version_seen;
    type_seen_next    = type_seen;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    has_res           = 1'b0;
    res               = '0;
    case (state)
      S_HUNT: begin
        if (byte_value == head_byte) state_next = S_VER;
      end
      S_VER: begin
        if (ver_in_ok) begin
          version_seen_next = byte_value;
          running_crc_next  = crc_upd;
          state_next        = S_TYPE;
        end else if (byte_value != head_byte) begin
          state_next = S_HUNT;
        end
      end
      S_TYPE: begin
        type_seen_next   = byte_value;
        running_crc_next = crc_upd;
        state_next       = S_LEN_LO;
      end
      S_LEN_LO: begin
        payload_len_next = {{(LenW-ByteW){1'b0}}, byte_value};
        running_crc_next = crc_upd;
        state_next       = S_LEN_HI;
      end
      S_LEN_HI: begin
        payload_len_next = len_full;
        running_crc_next = crc_upd;
        remain_next      = len_full;
        if (len_full > max_payload) begin
          has_res           = 1'b1;
          res.kind          = KIND_STATUS;
          res.status        = ST_TOO_LONG;
          res.frame_version = version_seen;
          res.frame_type    = type_seen;
          res.frame_length  = len_full;
          // a head byte here opens a new frame
          state_next = (byte_value == head_byte) ? S_VER : S_HUNT;
        end else if (len_full == '0) begin
          state_next = S_CRC_LO;
        end else begin
          state_next = S_PAY;
        end
      end
      S_PAY: begin
        running_crc_next = crc_upd;
        remain_next      = remain - {{(LenW-1){1'b0}}, 1'b1};
        has_res          = 1'b1;
        res.kind         = KIND_DATA;
        res.data_byte    = byte_value;
        if (remain == {{(LenW-1){1'b0}}, 1'b1}) state_next = S_CRC_LO;
      end
      S_CRC_LO: begin
        crc_low_byte_next = byte_value;
        state_next        = S_CRC_HI;
      end
      S_CRC_HI: begin
        // leaves zero on a match
        running_crc_next = running_crc ^ {byte_value, crc_low_byte};
        state_next       = S_TAIL;
      end
      S_TAIL: begin
        has_res           = 1'b1;
        res.kind          = KIND_STATUS;
        res.frame_version = version_seen;
        res.frame_type    = type_seen;
        res.frame_length  = payload_len;
        if (!ver_seen_ok) begin
          res.status = ST_BAD_VER;
        end else if (byte_value != tail_byte) begin
          res.status = ST_BAD_TAIL;
        end else if (running_crc != '0) begin
          res.status = ST_BAD_CRC;
        end else begin
          res.status = ST_OK;
        end
        state_next = S_HUNT;
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_HUNT;
      payload_len  <= '0;
      remain       <= '0;
      version_seen <= '0;
      type_seen    <= '0;
      running_crc  <= CrcInit;
      crc_low_byte <= '0;
    end else if (in_fire) begin
      state        <= state_next;
      payload_len  <= payload_len_next;
      remain       <= remain_next;
      version_seen <= version_seen_next;
      type_seen    <= type_seen_next;
      running_crc  <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
        if (push) skid_reg <= res;
      end else if (push) begin
        out_reg <= res;
      end
    end else if (push) begin
      skid_reg <= res;
    end
  end

  assign kind          = out_reg.kind;
  assign data_byte     = out_reg.data_byte;
  assign status        = out_reg.status;
  assign frame_version = out_reg.frame_version;
  assign frame_type    = out_reg.frame_type;
  assign frame_length  = out_reg.frame_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_pay_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAY) |-> (remain != '0))
    else $error("payload state with no bytes left");

  a_tail_ends: assert property (@(posedge clk) disable iff (rst)
    (in_fire && state == S_TAIL) |=> (state == S_HUNT))
    else $error("frame did not end after tail word");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DATA) |-> (status == '0 && frame_length == '0))
    else $error("payload word carries status fields");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the length-prefixed frame deframer with running CRC-16/MODBUS.
module tb;
  import bfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRegs      = 5;
  localparam int NumPhases    = 7;
  localparam int ItemsPerPhase = 236;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 1000000;

  // frame byte offsets: position counts frame bytes taken so far
  localparam logic [16:0] PosHunt  = 17'd0;
  localparam logic [16:0] PosVer   = 17'd1;
  localparam logic [16:0] PosType  = 17'd2;
  localparam logic [16:0] PosLenLo = 17'd3;
  localparam logic [16:0] PosLenHi = 17'd4;
  localparam logic [16:0] PosPay   = 17'd5;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    frame_status_t    status;
    logic [7:0]       version;
    logic [7:0]       msg_type;
    logic [15:0]      length;
  } frame_word_t;

  // where the byte of a stimulus word comes from; CRC bytes are xored with value
  typedef enum logic [1:0] {
    SRC_RAW,
    SRC_CRC_LO,
    SRC_CRC_HI
  } byte_src_t;

  typedef struct {
    logic [7:0]  value;
    byte_src_t   src;
    bit          typed;
    frame_word_t want;
  } link_tok_t;

  localparam frame_word_t NoWord = '0;

  localparam int NumDirRows = 26;
  link_tok_t dir_rows [NumDirRows] = '{
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    '{8'hAA, SRC_RAW, 1'b0, NoWord},
    '{8'hAA, SRC_RAW, 1'b0, NoWord},
    '{8'h01, SRC_RAW, 1'b0, NoWord},
    '{8'h07, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    // length 0xAA00 is too long and its high byte reopens a frame
    '{8'hAA, SRC_RAW, 1'b1, '{KIND_STATUS, 8'h00, ST_TOO_LONG, 8'h01, 8'h07, 16'hAA00}},
    '{8'h02, SRC_RAW, 1'b0, NoWord},
    '{8'hFF, SRC_RAW, 1'b0, NoWord},
    '{8'h02, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b1, '{KIND_DATA, 8'h00, ST_OK, 8'h00, 8'h00, 16'h0000}},
    '{8'hFF, SRC_RAW, 1'b1, '{KIND_DATA, 8'hFF, ST_OK, 8'h00, 8'h00, 16'h0000}},
    '{8'h00, SRC_CRC_LO, 1'b0, NoWord},
    '{8'h00, SRC_CRC_HI, 1'b0, NoWord},
    '{8'h55, SRC_RAW, 1'b1, '{KIND_STATUS, 8'h00, ST_OK, 8'h02, 8'hFF, 16'h0002}},
    '{8'hAA, SRC_RAW, 1'b0, NoWord},
    '{8'h03, SRC_RAW, 1'b0, NoWord},
    '{8'hAA, SRC_RAW, 1'b0, NoWord},
    '{8'h01, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b0, NoWord},
    '{8'h12, SRC_RAW, 1'b0, NoWord},
    '{8'h34, SRC_RAW, 1'b0, NoWord},
    '{8'h00, SRC_RAW, 1'b1, '{KIND_STATUS, 8'h00, ST_BAD_TAIL, 8'h01, 8'h00, 16'h0000}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    byte_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                kind;
  logic [ByteW-1:0]    data_byte;
  logic [StW-1:0]      status;
  logic [ByteW-1:0]    frame_version;
  logic [ByteW-1:0]    frame_type;
  logic [LenW-1:0]     frame_length;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // register copies
  logic [7:0]  cfg_head;
  logic [7:0]  cfg_tail;
  logic [7:0]  cfg_ver_a;
  logic [7:0]  cfg_ver_b;
  logic [15:0] cfg_max_len;

  // deframer state copy
  logic [16:0] fpos;
  logic [15:0] len_seen;
  logic [7:0]  ver_seen;
  logic [7:0]  type_seen;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;

  frame_word_t frame_words_due [$];
  link_tok_t   link_toks [$];
  int          n_errors = 0;
  int          cycle_cnt = 0;
  int          stall_cnt = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;

  ble_frame_deframer_crc16_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_value(byte_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .data_byte(data_byte), .status(status),
    .frame_version(frame_version), .frame_type(frame_type), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic bit ver_accepted(input logic [7:0] v);
    return (v == cfg_ver_a) || (v == cfg_ver_b);
  endfunction

  function automatic frame_word_t status_word(input frame_status_t st);
    frame_word_t w;
    w = NoWord;
    w.kind = KIND_STATUS;
    w.status = st;
    w.version = ver_seen;
    w.msg_type = type_seen;
    w.length = len_seen;
    return w;
  endfunction

  // advance the deframer copy by one link byte
  function automatic void deframe_step(input logic [7:0] b, output bit has,
                                       output frame_word_t w);
    logic [16:0] k;
    has = 1'b0;
    w = NoWord;
    if (fpos == PosHunt) begin
      if (b == cfg_head) fpos = PosVer;
    end else if (fpos == PosVer) begin
      if (ver_accepted(b)) begin
        ver_seen = b;
        crc_acc = crc_update(CrcInit, b);
        fpos = PosType;
      end else if (b != cfg_head) begin
        fpos = PosHunt;
      end
    end else if (fpos == PosType) begin
      type_seen = b;
      crc_acc = crc_update(crc_acc, b);
      fpos = PosLenLo;
    end else if (fpos == PosLenLo) begin
      len_seen = {8'h00, b};
      crc_acc = crc_update(crc_acc, b);
      fpos = PosLenHi;
    end else if (fpos == PosLenHi) begin
      len_seen[15:8] = b;
      crc_acc = crc_update(crc_acc, b);
      if (len_seen > cfg_max_len) begin
        has = 1'b1;
        w = status_word(ST_TOO_LONG);
        fpos = (b == cfg_head) ? PosVer : PosHunt;
      end else begin
        fpos = PosPay;
      end
    end else begin
      k = fpos - PosPay;
      if (k < {1'b0, len_seen}) begin
        crc_acc = crc_update(crc_acc, b);
        fpos = fpos + 17'd1;
        has = 1'b1;
        w.kind = KIND_DATA;
        w.data = b;
      end else if (k == {1'b0, len_seen}) begin
        crc_lo = b;
        fpos = fpos + 17'd1;
      end else if (k == {1'b0, len_seen} + 17'd1) begin
        crc_acc = crc_acc ^ {b, crc_lo};
        fpos = fpos + 17'd1;
      end else begin
        has = 1'b1;
        if (!ver_accepted(ver_seen)) w = status_word(ST_BAD_VER);
        else if (b != cfg_tail) w = status_word(ST_BAD_TAIL);
        else if (crc_acc != 16'h0000) w = status_word(ST_BAD_CRC);
        else w = status_word(ST_OK);
        fpos = PosHunt;
      end
    end
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] good_length();
    int unsigned cap;
    int r;
    cap = (cfg_max_len < 16'd300) ? int'(cfg_max_len) : 300;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, (cap < 6) ? cap : 6));
    if (r < 95) return 16'($urandom_range(0, (cap < 40) ? cap : 40));
    return 16'($urandom_range(0, cap));
  endfunction

  function automatic logic [7:0] accepted_version();
    return $urandom_range(0, 1) ? cfg_ver_a : cfg_ver_b;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_raw(input logic [7:0] v);
    link_toks.push_back('{v, SRC_RAW, 1'b0, NoWord});
  endtask

  task automatic push_frame(input logic [7:0] ver, input logic [15:0] len,
                            input logic [7:0] lo_mask, input logic [7:0] hi_mask,
                            input logic [7:0] tail_val);
    push_raw(cfg_head);
    push_raw(ver);
    push_raw(rand_byte());
    push_raw(len[7:0]);
    push_raw(len[15:8]);
    repeat (len) push_raw(rand_byte());
    link_toks.push_back('{lo_mask, SRC_CRC_LO, 1'b0, NoWord});
    link_toks.push_back('{hi_mask, SRC_CRC_HI, 1'b0, NoWord});
    push_raw(tail_val);
  endtask

  task automatic send_tok(input link_tok_t tk);
    int gap;
    logic [7:0] b;
    bit has;
    frame_word_t w;
    gap = pick_gap(quiet_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    case (tk.src)
      SRC_CRC_LO: b = crc_acc[7:0] ^ tk.value;
      SRC_CRC_HI: b = crc_acc[15:8] ^ tk.value;
      default:    b = tk.value;
    endcase
    deframe_step(b, has, w);
    if (tk.typed) frame_words_due.push_back(tk.want);
    else if (has) frame_words_due.push_back(w);
    in_valid <= 1'b1;
    byte_value <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush_toks(inout int sent);
    while (link_toks.size() != 0) begin
      send_tok(link_toks.pop_front());
      sent++;
    end
  endtask

  // hold input until every expected word is out, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEAD:   cfg_head = data[7:0];
      REG_TAIL:   cfg_tail = data[7:0];
      REG_VER1:   cfg_ver_a = data[7:0];
      REG_VER2:   cfg_ver_b = data[7:0];
      REG_MAXPAY: cfg_max_len = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $error("timeout after %0d cycles, %0d words still expected", cycle_cnt,
             frame_words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : check_words
    frame_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frame_words_due.size() == 0) begin
          $error("word with nothing expected: kind %0d data %0h status %0d", kind, data_byte,
                 status);
          n_errors++;
        end else begin
          want = frame_words_due.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            n_errors++;
          end
          if (data_byte !== want.data) begin
            $error("data_byte: expected %0h, got %0h", want.data, data_byte);
            n_errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            n_errors++;
          end
          if (frame_version !== want.version) begin
            $error("frame_version: expected %0h, got %0h", want.version, frame_version);
            n_errors++;
          end
          if (frame_type !== want.msg_type) begin
            $error("frame_type: expected %0h, got %0h", want.msg_type, frame_type);
            n_errors++;
          end
          if (frame_length !== want.length) begin
            $error("frame_length: expected %0h, got %0h", want.length, frame_length);
            n_errors++;
          end
        end
      end
      if (stall_cnt == 0 && !quiet_out && $urandom_range(0, 2) == 0) begin
        stall_cnt = pick_gap(1'b0);
      end
      if (stall_cnt != 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0]  h, t, va, vb, bv;
    logic [15:0] m, ln;
    int          sent;
    int          r;

    cfg_head = HeadReset;
    cfg_tail = TailReset;
    cfg_ver_a = FirstVerReset;
    cfg_ver_b = SecondVerReset;
    cfg_max_len = MaxPayReset;
    fpos = PosHunt;
    len_seen = '0;
    ver_seen = '0;
    type_seen = '0;
    crc_acc = CrcInit;
    crc_lo = '0;
    sent = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirRows; i++) send_tok(dir_rows[i]);

    // versions change while a frame waits at its CRC: the tail must report bad version
    push_raw(8'hAA);
    push_raw(8'h01);
    push_raw(8'h05);
    push_raw(8'h00);
    push_raw(8'h00);
    flush_toks(sent);
    settle();
    cfg_write(REG_VER1, 16'h0010);
    cfg_write(REG_VER2, 16'h0020);
    link_toks.push_back('{8'h00, SRC_CRC_LO, 1'b0, NoWord});
    link_toks.push_back('{8'h00, SRC_CRC_HI, 1'b0, NoWord});
    link_toks.push_back('{8'h55, SRC_RAW, 1'b1,
                          '{KIND_STATUS, 8'h00, ST_BAD_VER, 8'h01, 8'h05, 16'h0000}});
    flush_toks(sent);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      h = rand_byte();
      t = rand_byte();
      va = rand_byte();
      vb = rand_byte();
      m = 16'($urandom_range(0, 400));
      case (ph)
        0: begin h = HeadReset; t = TailReset; va = FirstVerReset; vb = SecondVerReset;
                 m = MaxPayReset; end
        1: begin h = 8'h00; t = 8'hFF; va = 8'h00; vb = 8'hFF; m = 16'd0; end
        2: begin h = 8'hFF; t = 8'h00; va = 8'hFF; vb = 8'h80; m = 16'hFFFF; end
        3: m = 16'd65527;
        4: begin vb = va; m = 16'd8; end
        6: m = 16'd1;
        default: ;
      endcase
      cfg_write(REG_HEAD, {rand_byte(), h});
      cfg_write(REG_TAIL, {rand_byte(), t});
      cfg_write(REG_VER1, {rand_byte(), va});
      cfg_write(REG_VER2, {rand_byte(), vb});
      cfg_write(REG_MAXPAY, m);
      // indexes past the last register must leave everything alone
      cfg_write(CfgIdxW'(NumRegs + $urandom_range(0, 2)), 16'($urandom_range(0, 65535)));

      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(0, 29) == 0) begin
          quiet_in = ($urandom_range(0, 3) == 0);
          quiet_out = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
          if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_raw(cfg_head);
          push_frame(accepted_version(), good_length(), 8'h00, 8'h00, cfg_tail);
        end else if (r < 63) begin
          bv = 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1)) push_frame(accepted_version(), good_length(), bv, 8'h00,
                                               cfg_tail);
          else push_frame(accepted_version(), good_length(), 8'h00, bv, cfg_tail);
        end else if (r < 70) begin
          push_frame(accepted_version(), good_length(), 8'h00, 8'h00,
                     cfg_tail ^ 8'($urandom_range(1, 255)));
        end else if (r < 78) begin
          if (cfg_max_len == 16'hFFFF) begin
            push_frame(accepted_version(), good_length(), 8'h00, 8'h00, cfg_tail);
          end else begin
            ln = {cfg_head, rand_byte()};
            if ($urandom_range(0, 2) != 0 || ln <= cfg_max_len) begin
              ln = ($urandom_range(0, 3) == 0) ? cfg_max_len + 16'd1 :
                   16'($urandom_range(cfg_max_len + 1, 65535));
            end
            push_raw(cfg_head);
            push_raw(accepted_version());
            push_raw(rand_byte());
            push_raw(ln[7:0]);
            push_raw(ln[15:8]);
          end
        end else if (r < 84) begin
          do bv = rand_byte(); while (bv == cfg_ver_a || bv == cfg_ver_b || bv == cfg_head);
          push_raw(cfg_head);
          push_raw(bv);
        end else if (r < 92) begin
          repeat ($urandom_range(1, 6)) push_raw(rand_byte());
        end else if (r < 96) begin
          // cut the header short
          push_raw(cfg_head);
          if ($urandom_range(0, 1)) begin
            push_raw(accepted_version());
            if ($urandom_range(0, 1)) push_raw(rand_byte());
          end
        end else begin
          push_frame(accepted_version(), 16'd0, 8'h00, 8'h00, cfg_tail);
        end
        flush_toks(sent);
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
